>>> rtl/tlqs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlqs_pkg: thick line quad setup shared definitions
// Register codes, fixed field widths and the status word of the serial units.
// ----------------------------------------------------------------------------
package tlqs_pkg;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 10;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_WIDTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_INSET      = 1'b1;

  localparam int unsigned HW_W    = 4;
  localparam int unsigned INSET_W = 10;
  localparam logic [HW_W-1:0]    HW_RESET    = 4'd4;
  localparam logic [INSET_W-1:0] INSET_RESET = 10'd384;

  // result fields
  localparam int unsigned CORNER_W = 14;
  localparam int unsigned LEN_W    = 14;
  localparam int unsigned TINT_W   = 16;
  localparam int unsigned BLEND_W  = 5;
  localparam logic [BLEND_W-1:0] BLEND_FIRST = 5'd2;
  localparam logic [BLEND_W-1:0] BLEND_LAST  = 5'd30;

  // 4.8 normal magnitude: |n| <= half_width * 256 < 2**QUO_W
  localparam int unsigned FRAC_W      = 8;
  localparam int unsigned QUO_W       = HW_W + FRAC_W;
  localparam int unsigned INSET_SHIFT = 16;
  // (2*n) asr 8 is n asr 7
  localparam int unsigned OUT_SHIFT   = 7;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

>>> rtl/tlqs_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlqs_if: segment and quad channels
// Valid/ready channels carrying one segment in and one quad out.
// ----------------------------------------------------------------------------
interface tlqs_in_if import tlqs_pkg::*; #(
  parameter int unsigned COORD_BITS = 13
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] start_x;
  logic signed [COORD_BITS-1:0] start_y;
  logic signed [COORD_BITS-1:0] end_x;
  logic signed [COORD_BITS-1:0] end_y;
  logic [TINT_W-1:0]            tint;

  modport source (output valid, start_x, start_y, end_x, end_y, tint, input ready);
  modport sink   (input valid, start_x, start_y, end_x, end_y, tint, output ready);
endinterface

interface tlqs_out_if import tlqs_pkg::*;;
  logic                       valid;
  logic                       ready;
  logic signed [CORNER_W-1:0] corner_a_x;
  logic signed [CORNER_W-1:0] corner_a_y;
  logic signed [CORNER_W-1:0] corner_b_x;
  logic signed [CORNER_W-1:0] corner_b_y;
  logic signed [CORNER_W-1:0] corner_c_x;
  logic signed [CORNER_W-1:0] corner_c_y;
  logic signed [CORNER_W-1:0] corner_d_x;
  logic signed [CORNER_W-1:0] corner_d_y;
  logic [LEN_W-1:0]           segment_length;
  logic [TINT_W-1:0]          tint_out;
  logic [BLEND_W-1:0]         blend_level;
  logic                       degenerate;

  modport source (output valid, corner_a_x, corner_a_y, corner_b_x, corner_b_y,
                  corner_c_x, corner_c_y, corner_d_x, corner_d_y, segment_length,
                  tint_out, blend_level, degenerate, input ready);
  modport sink   (input valid, corner_a_x, corner_a_y, corner_b_x, corner_b_y,
                  corner_c_x, corner_c_y, corner_d_x, corner_d_y, segment_length,
                  tint_out, blend_level, degenerate, output ready);
endinterface

>>> rtl/tlqs_sqsum.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlqs_sqsum: serial sum of two squares
// Shift-add a*a + b*b, one multiplier bit of each operand per cycle.
// ----------------------------------------------------------------------------
module tlqs_sqsum import tlqs_pkg::*; #(
  parameter int unsigned MAG_W = 14
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [MAG_W-1:0]   mag_a_i,
  input  logic [MAG_W-1:0]   mag_b_i,
  output unit_stat_t         stat_o,
  output logic [2*MAG_W-1:0] sum_o
);
  localparam int unsigned SUM_W = 2 * MAG_W;
  localparam int unsigned CNT_W = $clog2(MAG_W + 1);

  logic [MAG_W-1:0] mul_a_q, mul_b_q;
  logic [SUM_W-1:0] addend_a_q, addend_b_q, acc_q;
  logic [SUM_W-1:0] part_a, part_b;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q, done_q;

  assign part_a = mul_a_q[0] ? addend_a_q : '0;
  assign part_b = mul_b_q[0] ? addend_b_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(MAG_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mul_a_q    <= mag_a_i;
      mul_b_q    <= mag_b_i;
      addend_a_q <= SUM_W'(mag_a_i);
      addend_b_q <= SUM_W'(mag_b_i);
      acc_q      <= '0;
    end else if (busy_q) begin
      acc_q      <= acc_q + part_a + part_b;
      mul_a_q    <= mul_a_q >> 1;
      mul_b_q    <= mul_b_q >> 1;
      addend_a_q <= addend_a_q << 1;
      addend_b_q <= addend_b_q << 1;
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign sum_o       = acc_q;

endmodule

>>> rtl/tlqs_isqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlqs_isqrt: serial floor square root
// Digit-by-digit root: two radicand bits in, one root bit out per cycle.
// ----------------------------------------------------------------------------
module tlqs_isqrt import tlqs_pkg::*; #(
  parameter int unsigned ROOT_W = 14
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [2*ROOT_W-1:0] rad_i,
  output unit_stat_t          stat_o,
  output logic [ROOT_W-1:0]   root_o
);
  localparam int unsigned RAD_W = 2 * ROOT_W;
  localparam int unsigned REM_W = ROOT_W + 1;
  localparam int unsigned TRY_W = ROOT_W + 3;
  localparam int unsigned CNT_W = $clog2(ROOT_W + 1);

  logic [RAD_W-1:0]  rad_q;
  logic [REM_W-1:0]  rem_q;
  logic [ROOT_W-1:0] root_q;
  logic [TRY_W-1:0]  try_rem, try_sub, try_diff;
  logic              take;
  logic [CNT_W-1:0]  cnt_q;
  logic              busy_q, done_q;

  assign try_rem  = {rem_q, rad_q[RAD_W-1 -: 2]};
  assign try_sub  = TRY_W'({root_q, 2'b01});
  assign take     = try_rem >= try_sub;
  assign try_diff = try_rem - try_sub;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(ROOT_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= rad_q << 2;
      // remainder stays at most twice the partial root
      rem_q  <= take ? try_diff[REM_W-1:0] : try_rem[REM_W-1:0];
      root_q <= {root_q[ROOT_W-2:0], take};
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign root_o      = root_q;

endmodule

>>> rtl/tlqs_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlqs_div: serial restoring divider
// One quotient bit per cycle; the dividend's upper part must be below the
// divisor, which bounds the quotient to QUO_W bits.
// ----------------------------------------------------------------------------
module tlqs_div import tlqs_pkg::*; #(
  parameter int unsigned DIV_W = 14
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [DIV_W+QUO_W-1:0] dividend_i,
  input  logic [DIV_W-1:0]       divisor_i,
  output unit_stat_t             stat_o,
  output logic [QUO_W-1:0]       quo_o
);
  localparam int unsigned CNT_W = $clog2(QUO_W + 1);

  logic [DIV_W-1:0] rem_q, dvs_q;
  logic [QUO_W-1:0] low_q, quo_q;
  logic [DIV_W:0]   try_rem, try_diff;
  logic             take;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q, done_q;

  assign try_rem  = {rem_q, low_q[QUO_W-1]};
  assign take     = try_rem >= {1'b0, dvs_q};
  assign try_diff = try_rem - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(QUO_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= dividend_i[DIV_W+QUO_W-1:QUO_W];
      low_q <= dividend_i[QUO_W-1:0];
      dvs_q <= divisor_i;
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= take ? try_diff[DIV_W-1:0] : try_rem[DIV_W-1:0];
      low_q <= low_q << 1;
      quo_q <= {quo_q[QUO_W-2:0], take};
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quo_o       = quo_q;

endmodule

>>> rtl/thick_line_quad_setup_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thick_line_quad_setup_top: thick line quad setup
// Expands a segment into the four corners of a quad that draws it as a
// thick line, with length, tint and a cycling blend level.
// ----------------------------------------------------------------------------
//   port    dir  handshake     carries
//   cfg_*   in   write enable  half_width (index 0), inset_factor (index 1)
//   seg_i   in   valid/ready   start_x, start_y, end_x, end_y, tint
//   quad_o  out  valid/ready   four corners, segment_length, tint_out, ...
//
// One segment at a time; the time from transfer in to quad ready is set by
// the bit-serial square sum and square root and the 12-step normal division.
// The next segment is taken while a finished quad waits in the output
// register; a stalled output holds the block at its last step.
// Reset clears the sequencer, the output valid, the blend counter (to 2) and
// the registers to their defaults.
// ----------------------------------------------------------------------------
module thick_line_quad_setup_top import tlqs_pkg::*; #(
  parameter int unsigned COORD_BITS = 13
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  tlqs_in_if.sink               seg_i,
  tlqs_out_if.source            quad_o
);
  localparam int unsigned MAG_W  = COORD_BITS + 1;
  localparam int unsigned SQ_W   = 2 * MAG_W;
  localparam int unsigned NUM_W  = MAG_W + QUO_W;
  localparam int unsigned SCL_W  = HW_W + MAG_W;
  localparam int unsigned NRM_W  = QUO_W + 1;
  localparam int unsigned PROD_W = NRM_W + INSET_W + 1;
  localparam int unsigned IN_W   = PROD_W - INSET_SHIFT;
  localparam int unsigned EXT_W  = ((COORD_BITS > CORNER_W) ? COORD_BITS : CORNER_W) + 2;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SQ   = 3'd1;
  localparam logic [2:0] S_ROOT = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_MUL  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0] state_q, state_d;

  logic [HW_W-1:0]    hw_q;
  logic [INSET_W-1:0] inset_q;
  logic [BLEND_W-1:0] blend_q;

  logic signed [COORD_BITS-1:0] sx_q, sy_q, ex_q, ey_q;
  logic [TINT_W-1:0]            tint_q;
  logic                         neg_x_q, neg_y_q;
  logic [MAG_W-1:0]             mag_x_q, mag_y_q, len_q;
  logic                         degen_q;
  logic signed [NRM_W-1:0]      nx_q, ny_q;
  logic signed [IN_W-1:0]       inx_q, iny_q;

  logic                 seg_xfer, load_out;
  logic signed [MAG_W-1:0] px, py;
  logic [MAG_W-1:0]     px_mag, py_mag;

  unit_stat_t           sq_stat, root_stat, div_x_stat, div_y_stat;
  logic [SQ_W-1:0]      sq_sum;
  logic [MAG_W-1:0]     root;
  logic [SCL_W-1:0]     scaled_x, scaled_y;
  logic [NUM_W-1:0]     num_x, num_y;
  logic [QUO_W-1:0]     quo_x, quo_y;
  logic signed [NRM_W-1:0]  nx_d, ny_d;
  logic signed [PROD_W-1:0] prod_x, prod_y;
  logic signed [EXT_W-1:0]  ofs_in_x, ofs_in_y, ofs_out_x, ofs_out_y;
  logic signed [EXT_W-1:0]  corner_ax, corner_ay, corner_bx, corner_by;
  logic signed [EXT_W-1:0]  corner_cx, corner_cy, corner_dx, corner_dy;

  logic out_valid_q;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hw_q    <= HW_RESET;
      inset_q <= INSET_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_HALF_WIDTH: hw_q    <= cfg_wdata_i[HW_W-1:0];
        CFG_INSET:      inset_q <= cfg_wdata_i[INSET_W-1:0];
        default: ;
      endcase
    end
  end

  assign seg_i.ready = (state_q == S_IDLE);
  assign seg_xfer    = seg_i.valid && seg_i.ready;

  // perpendicular (start_y - end_y, end_x - start_x) and its magnitudes
  assign px     = MAG_W'(seg_i.start_y) - MAG_W'(seg_i.end_y);
  assign py     = MAG_W'(seg_i.end_x) - MAG_W'(seg_i.start_x);
  assign px_mag = px[MAG_W-1] ? MAG_W'(-px) : MAG_W'(px);
  assign py_mag = py[MAG_W-1] ? MAG_W'(-py) : MAG_W'(py);

  tlqs_sqsum #(.MAG_W(MAG_W)) u_sqsum (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (seg_xfer),
    .mag_a_i (px_mag),
    .mag_b_i (py_mag),
    .stat_o  (sq_stat),
    .sum_o   (sq_sum)
  );

  tlqs_isqrt #(.ROOT_W(MAG_W)) u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_stat.done),
    .rad_i   (sq_sum),
    .stat_o  (root_stat),
    .root_o  (root)
  );

  // dividend is half_width * |p| in 18.8
  assign scaled_x = SCL_W'(hw_q) * SCL_W'(mag_x_q);
  assign scaled_y = SCL_W'(hw_q) * SCL_W'(mag_y_q);
  assign num_x    = {scaled_x, FRAC_W'(0)};
  assign num_y    = {scaled_y, FRAC_W'(0)};

  tlqs_div #(.DIV_W(MAG_W)) u_div_x (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (root_stat.done),
    .dividend_i (num_x),
    .divisor_i  (root),
    .stat_o     (div_x_stat),
    .quo_o      (quo_x)
  );

  tlqs_div #(.DIV_W(MAG_W)) u_div_y (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (root_stat.done),
    .dividend_i (num_y),
    .divisor_i  (root),
    .stat_o     (div_y_stat),
    .quo_o      (quo_y)
  );

  // restore the sign: division truncates toward zero
  assign nx_d = degen_q ? '0 : (neg_x_q ? -$signed({1'b0, quo_x}) : $signed({1'b0, quo_x}));
  assign ny_d = degen_q ? '0 : (neg_y_q ? -$signed({1'b0, quo_y}) : $signed({1'b0, quo_y}));

  assign prod_x = PROD_W'(nx_q) * $signed({1'b0, inset_q});
  assign prod_y = PROD_W'(ny_q) * $signed({1'b0, inset_q});

  assign ofs_in_x  = EXT_W'(inx_q);
  assign ofs_in_y  = EXT_W'(iny_q);
  assign ofs_out_x = (EXT_W'(nx_q) >>> OUT_SHIFT) - ofs_in_x;
  assign ofs_out_y = (EXT_W'(ny_q) >>> OUT_SHIFT) - ofs_in_y;

  assign corner_ax = EXT_W'(sx_q) + ofs_in_x;
  assign corner_ay = EXT_W'(sy_q) + ofs_in_y;
  assign corner_bx = EXT_W'(ex_q) + ofs_in_x;
  assign corner_by = EXT_W'(ey_q) + ofs_in_y;
  assign corner_cx = EXT_W'(ex_q) - ofs_out_x;
  assign corner_cy = EXT_W'(ey_q) - ofs_out_y;
  assign corner_dx = EXT_W'(sx_q) - ofs_out_x;
  assign corner_dy = EXT_W'(sy_q) - ofs_out_y;

  assign load_out = (state_q == S_OUT) && (!out_valid_q || quad_o.ready);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (seg_xfer)          state_d = S_SQ;
      S_SQ:   if (sq_stat.done)      state_d = S_ROOT;
      S_ROOT: if (root_stat.done)    state_d = S_DIV;
      S_DIV:  if (div_x_stat.done)   state_d = S_MUL;
      S_MUL:                         state_d = S_OUT;
      S_OUT:  if (load_out)          state_d = S_IDLE;
      default:                       state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      blend_q     <= BLEND_FIRST;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (seg_xfer) begin
        blend_q <= (blend_q inside {[BLEND_FIRST:BLEND_LAST]}) ? blend_q + 1'b1 : BLEND_FIRST;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (quad_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (seg_xfer) begin
      sx_q    <= seg_i.start_x;
      sy_q    <= seg_i.start_y;
      ex_q    <= seg_i.end_x;
      ey_q    <= seg_i.end_y;
      tint_q  <= seg_i.tint;
      neg_x_q <= px[MAG_W-1];
      neg_y_q <= py[MAG_W-1];
      mag_x_q <= px_mag;
      mag_y_q <= py_mag;
    end
    if (root_stat.done) begin
      len_q   <= root;
      degen_q <= (root == '0);
    end
    if (div_x_stat.done) begin
      nx_q <= nx_d;
      ny_q <= ny_d;
    end
    if (state_q == S_MUL) begin
      inx_q <= prod_x[PROD_W-1:INSET_SHIFT];
      iny_q <= prod_y[PROD_W-1:INSET_SHIFT];
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      quad_o.corner_a_x     <= corner_ax[CORNER_W-1:0];
      quad_o.corner_a_y     <= corner_ay[CORNER_W-1:0];
      quad_o.corner_b_x     <= corner_bx[CORNER_W-1:0];
      quad_o.corner_b_y     <= corner_by[CORNER_W-1:0];
      quad_o.corner_c_x     <= corner_cx[CORNER_W-1:0];
      quad_o.corner_c_y     <= corner_cy[CORNER_W-1:0];
      quad_o.corner_d_x     <= corner_dx[CORNER_W-1:0];
      quad_o.corner_d_y     <= corner_dy[CORNER_W-1:0];
      quad_o.segment_length <= LEN_W'(len_q);
      quad_o.tint_out       <= tint_q;
      quad_o.blend_level    <= blend_q;
      quad_o.degenerate     <= degen_q;
    end
  end

  assign quad_o.valid = out_valid_q;

`ifndef SYNTH
  a_sq_in_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_stat.busy |-> state_q == S_SQ)
    else $error("square sum running outside its step");

  a_root_in_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    root_stat.busy |-> state_q == S_ROOT)
    else $error("square root running outside its step");

  a_div_lockstep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_x_stat.busy |-> div_y_stat.busy && state_q == S_DIV)
    else $error("divider lanes out of step");

  a_degen_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    quad_o.valid && quad_o.degenerate |-> quad_o.segment_length == '0)
    else $error("degenerate quad with nonzero length");
`endif

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: thick line quad setup testbench
// Drives line segments into the block over its valid/ready channel and checks
// every quad against a predictor of the corner, length and blend level math or
// the typed table values. A table of directed segments runs first at the reset
// register values, then several register settings each get a batch of random
// segments, random idle bursts on both channels and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_top import tlqs_pkg::*;;

  localparam int CB              = 13;
  localparam int C_MIN           = -(1 << (CB - 1));
  localparam int C_MAX           = (1 << (CB - 1)) - 1;
  localparam int QUIET_CYC       = 2 * CB + 20 + 10;
  localparam int LONG_HOLD       = 300;
  localparam int N_PHASES        = 8;
  localparam int ITEMS_PER_PHASE = 110;
  localparam int TIMEOUT_NS      = 4_000_000;

  typedef struct {
    logic signed [CB-1:0] sx, sy, ex, ey;
    logic [TINT_W-1:0]    tint;
  } seg_t;

  typedef struct {
    logic [CORNER_W-1:0] ax, ay, bx, by, cx, cy, dx, dy;
    logic [LEN_W-1:0]    len;
    logic [TINT_W-1:0]   tint;
    logic [BLEND_W-1:0]  blend;
    logic                degen;
  } quad_t;

  // typed = 1: offsets, length and flag are given in the row itself
  typedef struct {
    seg_t s;
    bit   typed;
    int   t_len, t_inx, t_iny, t_outx, t_outy;
    bit   t_dg;
  } seg_row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  tlqs_in_if #(.COORD_BITS(CB)) seg_if ();
  tlqs_out_if                   quad_if ();

  thick_line_quad_setup_top #(.COORD_BITS(CB)) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .seg_i       (seg_if),
    .quad_o      (quad_if)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // predictor state
  logic [HW_W-1:0]    cfg_hw    = HW_RESET;
  logic [INSET_W-1:0] cfg_inset = INSET_RESET;
  logic [BLEND_W-1:0] blend_now = BLEND_FIRST;
  quad_t              quad_q[$];
  seg_row_t           dir_tab[$];

  bit calm     = 1'b0;
  bit hold_req = 1'b0;
  int n_err, n_sent, n_checked, n_degen, n_settings, n_holds;

  task automatic report(input string msg);
    $display("[%0t] MISMATCH %s", $time, msg);
    n_err++;
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want)
      report($sformatf("%s: got %h, expected %h", name, got, want));
  endtask

  function automatic quad_t build_quad(input seg_t s, input longint inx, iny,
                                       input longint outx, outy, len,
                                       input bit dg, input logic [BLEND_W-1:0] blend);
    quad_t q;
    q.ax    = longint'(s.sx) + inx;
    q.ay    = longint'(s.sy) + iny;
    q.bx    = longint'(s.ex) + inx;
    q.by    = longint'(s.ey) + iny;
    q.cx    = longint'(s.ex) - outx;
    q.cy    = longint'(s.ey) - outy;
    q.dx    = longint'(s.sx) - outx;
    q.dy    = longint'(s.sy) - outy;
    q.len   = len;
    q.tint  = s.tint;
    q.blend = blend;
    q.degen = dg;
    return q;
  endfunction

  function automatic quad_t predict_quad(input seg_t s, input logic [BLEND_W-1:0] blend);
    longint px, py, sq, len, trial, nx, ny, inx, iny, outx, outy;
    px   = longint'(s.sy) - longint'(s.ey);
    py   = longint'(s.ex) - longint'(s.sx);
    sq   = px * px + py * py;
    len  = 0;
    for (int b = LEN_W - 1; b >= 0; b--) begin
      trial = len | (longint'(1) << b);
      if (trial * trial <= sq) len = trial;
    end
    inx  = 0;
    iny  = 0;
    outx = 0;
    outy = 0;
    if (len != 0) begin
      // 4.8 normal magnitude, division truncates toward zero
      nx   = (longint'(cfg_hw) * px * 256) / len;
      ny   = (longint'(cfg_hw) * py * 256) / len;
      inx  = (nx * longint'(cfg_inset)) >>> INSET_SHIFT;
      iny  = (ny * longint'(cfg_inset)) >>> INSET_SHIFT;
      outx = ((2 * nx) >>> FRAC_W) - inx;
      outy = ((2 * ny) >>> FRAC_W) - iny;
    end
    return build_quad(s, inx, iny, outx, outy, len, len == 0, blend);
  endfunction

  function automatic seg_row_t mk_row(input int sx, sy, ex, ey, input int unsigned tint,
                                      input bit typed, input int len, inx, iny,
                                      input int outx, outy, input bit dg);
    seg_row_t r;
    r.s.sx   = sx;
    r.s.sy   = sy;
    r.s.ex   = ex;
    r.s.ey   = ey;
    r.s.tint = tint;
    r.typed  = typed;
    r.t_len  = len;
    r.t_inx  = inx;
    r.t_iny  = iny;
    r.t_outx = outx;
    r.t_outy = outy;
    r.t_dg   = dg;
    return r;
  endfunction

  function automatic logic signed [CB-1:0] edge_coord();
    case ($urandom_range(0, 3))
      0:       return C_MIN;
      1:       return C_MAX;
      2:       return 0;
      default: return -1;
    endcase
  endfunction

  function automatic seg_t rand_seg();
    seg_t        s;
    int unsigned pick;
    pick   = $urandom_range(0, 19);
    s.sx   = $urandom;
    s.sy   = $urandom;
    s.ex   = $urandom;
    s.ey   = $urandom;
    s.tint = $urandom;
    if (pick >= 8 && pick < 12) begin
      s.ex = s.sx + int'($urandom_range(0, 8)) - 4;
      s.ey = s.sy + int'($urandom_range(0, 8)) - 4;
    end else if (pick >= 12 && pick < 14) begin
      s.ex = s.sx;
      s.ey = s.sy;
    end else if (pick >= 14 && pick < 17) begin
      s.sx = edge_coord();
      s.sy = edge_coord();
      s.ex = edge_coord();
      s.ey = edge_coord();
    end else if (pick >= 17) begin
      if ($urandom_range(0, 1) == 1) s.ey = s.sy;
      else s.ex = s.sx;
    end
    case ($urandom_range(0, 15))
      0:       s.tint = '0;
      1:       s.tint = '1;
      default: ;
    endcase
    return s;
  endfunction

  function automatic int pick_gap();
    if (!calm && $urandom_range(0, 5) == 0) return int'($urandom_range(1, 16));
    return 0;
  endfunction

  // offer one segment; the expectation is formed at the edge of the transfer
  task automatic send_seg(input seg_row_t r, input int gap);
    quad_t q;
    if (gap > 0) begin
      seg_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    seg_if.valid   <= 1'b1;
    seg_if.start_x <= r.s.sx;
    seg_if.start_y <= r.s.sy;
    seg_if.end_x   <= r.s.ex;
    seg_if.end_y   <= r.s.ey;
    seg_if.tint    <= r.s.tint;
    do @(posedge clk_i); while (!seg_if.ready);
    if (blend_now >= BLEND_FIRST && blend_now <= BLEND_LAST) blend_now = blend_now + 1'b1;
    else blend_now = BLEND_FIRST;
    if (r.typed)
      q = build_quad(r.s, r.t_inx, r.t_iny, r.t_outx, r.t_outy, r.t_len, r.t_dg, blend_now);
    else
      q = predict_quad(r.s, blend_now);
    quad_q.push_back(q);
    n_sent++;
    if (q.degen) n_degen++;
    @(negedge clk_i);
  endtask

  task automatic write_regs(input logic [CFG_DATA_W-1:0] hw_word, inset_word);
    while (quad_q.size() != 0) @(negedge clk_i);
    repeat (QUIET_CYC) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_HALF_WIDTH;
    cfg_wdata_i <= hw_word;
    @(negedge clk_i);
    cfg_idx_i   <= CFG_INSET;
    cfg_wdata_i <= inset_word;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    cfg_hw    = hw_word[HW_W-1:0];
    cfg_inset = inset_word[INSET_W-1:0];
    n_settings++;
  endtask

  // output side: random stalls, plus one long hold-off on request
  initial begin
    quad_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        quad_if.ready <= 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk_i);
        hold_req = 1'b0;
        n_holds++;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        quad_if.ready <= 1'b0;
        repeat ($urandom_range(1, 16) - 1) @(negedge clk_i);
      end else begin
        quad_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : quad_check
    quad_t got, want;
    if (rst_ni && quad_if.valid && quad_if.ready) begin
      got.ax    = quad_if.corner_a_x;
      got.ay    = quad_if.corner_a_y;
      got.bx    = quad_if.corner_b_x;
      got.by    = quad_if.corner_b_y;
      got.cx    = quad_if.corner_c_x;
      got.cy    = quad_if.corner_c_y;
      got.dx    = quad_if.corner_d_x;
      got.dy    = quad_if.corner_d_y;
      got.len   = quad_if.segment_length;
      got.tint  = quad_if.tint_out;
      got.blend = quad_if.blend_level;
      got.degen = quad_if.degenerate;
      if (quad_q.size() == 0) begin
        report("quad transfer with no segment pending");
      end else begin
        want = quad_q.pop_front();
        check_field("corner_a_x", got.ax, want.ax);
        check_field("corner_a_y", got.ay, want.ay);
        check_field("corner_b_x", got.bx, want.bx);
        check_field("corner_b_y", got.by, want.by);
        check_field("corner_c_x", got.cx, want.cx);
        check_field("corner_c_y", got.cy, want.cy);
        check_field("corner_d_x", got.dx, want.dx);
        check_field("corner_d_y", got.dy, want.dy);
        check_field("segment_length", got.len, want.len);
        check_field("tint_out", got.tint, want.tint);
        check_field("blend_level", got.blend, want.blend);
        check_field("degenerate", got.degen, want.degen);
        n_checked++;
      end
    end
  end

  initial begin : stimulus
    logic [CFG_DATA_W-1:0] hw_word, inset_word;
    seg_row_t              r;
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = CFG_HALF_WIDTH;
    cfg_wdata_i    = '0;
    seg_if.valid   = 1'b0;
    seg_if.start_x = '0;
    seg_if.start_y = '0;
    seg_if.end_x   = '0;
    seg_if.end_y   = '0;
    seg_if.tint    = '0;

    // at reset values: half width 4, inset 1.5, so a unit normal is 1024
    // and splits into 6 inward and 2 outward
    dir_tab.push_back(mk_row(0, 0, 0, 0, 'h0000, 1, 0, 0, 0, 0, 0, 1));
    dir_tab.push_back(mk_row(C_MIN, C_MIN, C_MIN, C_MIN, 'hFFFF, 1, 0, 0, 0, 0, 0, 1));
    dir_tab.push_back(mk_row(C_MAX, C_MAX, C_MAX, C_MAX, 'h5555, 1, 0, 0, 0, 0, 0, 1));
    dir_tab.push_back(mk_row(0, 0, 100, 0, 'hAAAA, 1, 100, 0, 6, 0, 2, 0));
    dir_tab.push_back(mk_row(0, 0, 0, 100, 'h1234, 1, 100, -6, 0, -2, 0, 0));
    dir_tab.push_back(mk_row(C_MIN, 0, C_MAX, 0, 'h8001, 1, 8191, 0, 6, 0, 2, 0));
    dir_tab.push_back(mk_row(0, C_MIN, 0, C_MAX, 'h7FFE, 1, 8191, -6, 0, -2, 0, 0));
    dir_tab.push_back(mk_row(0, 0, 1, 0, 'h00FF, 1, 1, 0, 6, 0, 2, 0));
    dir_tab.push_back(mk_row(0, 0, 1, 1, 'hFF00, 1, 1, -6, 6, -2, 2, 0));
    dir_tab.push_back(mk_row(C_MIN, C_MIN, C_MAX, C_MAX, 'h0F0F, 0, 0, 0, 0, 0, 0, 0));
    dir_tab.push_back(mk_row(C_MAX, C_MIN, C_MIN, C_MAX, 'hF0F0, 0, 0, 0, 0, 0, 0, 0));
    dir_tab.push_back(mk_row(C_MIN, C_MAX, C_MAX, C_MIN, 'h3C3C, 0, 0, 0, 0, 0, 0, 0));
    dir_tab.push_back(mk_row(C_MAX, C_MAX, C_MIN, C_MIN, 'hC3C3, 0, 0, 0, 0, 0, 0, 0));
    dir_tab.push_back(mk_row(5, -7, -3, 2, 'h0001, 0, 0, 0, 0, 0, 0, 0));
    dir_tab.push_back(mk_row(-1, -1, 0, 0, 'h8000, 0, 0, 0, 0, 0, 0, 0));
    dir_tab.push_back(mk_row(100, 200, 103, 204, 'h6666, 0, 0, 0, 0, 0, 0, 0));
    dir_tab.push_back(mk_row(C_MIN, C_MIN, C_MIN + 1, C_MIN, 'h9999, 0, 0, 0, 0, 0, 0, 0));
    dir_tab.push_back(mk_row(1, 1, 0, 0, 'h4321, 0, 0, 0, 0, 0, 0, 0));

    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_tab[i]) send_seg(dir_tab[i], pick_gap());

    for (int ph = 0; ph < N_PHASES; ph++) begin
      seg_if.valid <= 1'b0;
      case (ph)
        0:       begin hw_word = 10'd0;     inset_word = 10'd0;     end
        1:       begin hw_word = 10'd15;    inset_word = 10'd512;   end
        2:       begin hw_word = 10'h3F1;   inset_word = 10'h3FF;   end
        3:       begin hw_word = 10'd15;    inset_word = 10'd0;     end
        4:       begin hw_word = 10'h2A9;   inset_word = 10'd1;     end
        default: begin
          hw_word    = $urandom_range(0, 1023);
          inset_word = $urandom_range(0, 1023);
        end
      endcase
      calm = (ph == N_PHASES - 1);
      write_regs(hw_word, inset_word);
      // keep offering while the output is held off so the block backs up
      if (ph == 3) hold_req = 1'b1;
      r.typed = 1'b0;
      repeat (ITEMS_PER_PHASE) begin
        r.s = rand_seg();
        send_seg(r, pick_gap());
      end
    end
    seg_if.valid <= 1'b0;

    while (quad_q.size() != 0) @(negedge clk_i);
    repeat (QUIET_CYC) @(negedge clk_i);

    $display("segments sent %0d (%0d from the table), quads checked %0d, zero length %0d",
             n_sent, dir_tab.size(), n_checked, n_degen);
    $display("register settings %0d, long output hold-offs %0d, mismatches %0d",
             n_settings, n_holds, n_err);
    if (n_err == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("timeout with %0d quads outstanding", quad_q.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule
